>>> rtl/assert_macros.svh
// Assertion macros used by the checker file.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`endif

>>> rtl/dpru_pkg.sv
// Package for the demand paging replacement unit: sizes, codes and command types.
// Used by the controller, the datapath and the top level.
package dpru_pkg;
  localparam int unsigned PageBytes = 256;
  localparam int unsigned Pages = 16;
  localparam int unsigned Frames = 4;
  localparam int unsigned OffW = $clog2(PageBytes);
  localparam int unsigned PageW = $clog2(Pages);
  localparam int unsigned FrameW = $clog2(Frames);
  localparam int unsigned AddrW = 12;
  localparam int unsigned PhysW = 10;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgDataW = 8;

  localparam logic [CfgIdxW-1:0] CfgPolicy = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgRefresh = 1'b1;

  typedef enum logic [1:0] {
    PolNru = 2'd0,
    PolFifo = 2'd1,
    PolClock = 2'd2,
    PolClockAlt = 2'd3
  } policy_e;

  typedef enum logic [2:0] {
    StIdle,
    StLookup,
    StNruScan,
    StClockScan,
    StCommit,
    StOut
  } state_e;

  typedef struct packed {
    logic start;       // latch input item
    logic free_load;   // load into free frame
    logic nru_step;    // examine one page
    logic clock_step;  // examine frame under hand
    logic commit;      // apply updates and build result
    logic out_valid;
  } cmd_t;

  typedef struct packed {
    logic hit;
    logic has_free;
    logic nru_done;
    logic clock_found;
  } stat_t;
endpackage

>>> rtl/dpru_stream_if.sv
// Valid/ready channel interface carrying one payload struct or vector.
// Depends on nothing.
interface dpru_stream_if #(parameter int unsigned W = 1);
  logic valid;
  logic ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> rtl/dpru_ctrl.sv
// Controller state machine for the paging unit.
// Depends on dpru_pkg.
module dpru_ctrl (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  logic out_ready_i,
  input  logic [1:0] policy_i,
  input  dpru_pkg::stat_t stat_i,
  output dpru_pkg::cmd_t cmd_o
);
  import dpru_pkg::*;
  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= StIdle;
    else state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d = StLookup;
        end
      end
      StLookup: begin
        if (stat_i.hit || stat_i.has_free) state_d = StCommit;
        else if (policy_i == PolNru) state_d = StNruScan;
        else if (policy_i == PolFifo) state_d = StCommit;
        else state_d = StClockScan;
      end
      StNruScan: begin
        cmd_o.nru_step = 1'b1;
        if (stat_i.nru_done) state_d = StCommit;
      end
      StClockScan: begin
        cmd_o.clock_step = 1'b1;
        if (stat_i.clock_found) state_d = StCommit;
      end
      StCommit: begin
        cmd_o.commit = 1'b1;
        state_d = StOut;
      end
      StOut: begin
        cmd_o.out_valid = 1'b1;
        if (out_ready_i) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end
endmodule

>>> rtl/dpru_datapath.sv
// Datapath of the paging unit: page table, frame table, victim search, result register.
// Depends on dpru_pkg.
module dpru_datapath (
  input  logic clk_i,
  input  logic rst_ni,
  input  dpru_pkg::cmd_t cmd_i,
  output dpru_pkg::stat_t stat_o,
  input  logic [1:0] policy_i,
  input  logic [dpru_pkg::CfgDataW-1:0] period_i,
  input  logic op_i,
  input  logic [dpru_pkg::AddrW-1:0] addr_i,
  output logic miss_o,
  output logic [dpru_pkg::FrameW-1:0] frame_index_o,
  output logic [dpru_pkg::PhysW-1:0] paddr_o,
  output logic evicted_o,
  output logic [dpru_pkg::PageW-1:0] victim_page_o
);
  import dpru_pkg::*;

  logic [FrameW-1:0] page_frame_q [Pages];
  logic [Pages-1:0] valid_q, ref_q, mod_q;
  logic [Frames-1:0] used_q;
  logic [PageW-1:0] owner_q [Frames];
  logic [FrameW-1:0] hand_q;
  logic [CfgDataW-1:0] tick_q;

  logic op_q;
  logic [PageW-1:0] page_q;
  logic [OffW-1:0] off_q;
  logic [PageW:0] scan_q;          // NRU scan index, one bit wider than a page number
  logic [PageW-1:0] best_q;
  logic [2:0] best_cls_q;
  logic [FrameW-1:0] hand_scan_q;
  logic [FrameW:0] clock_cnt_q;

  logic [FrameW-1:0] free_idx;
  logic has_free;
  always_comb begin
    free_idx = '0;
    has_free = 1'b0;
    for (int f = Frames - 1; f >= 0; f--) begin
      if (!used_q[f]) begin
        free_idx = FrameW'(f);
        has_free = 1'b1;
      end
    end
  end

  logic [PageW-1:0] scan_idx, clk_owner;
  logic [2:0] scan_cls;
  assign scan_idx = scan_q[PageW-1:0];
  assign scan_cls = {1'b0, ref_q[scan_idx], mod_q[scan_idx]};
  assign clk_owner = owner_q[hand_scan_q];

  assign stat_o.hit = valid_q[page_q];
  assign stat_o.has_free = has_free;
  assign stat_o.nru_done = (scan_q == (PageW+1)'(Pages - 1));
  assign stat_o.clock_found = !ref_q[clk_owner] ||
                              (clock_cnt_q == (FrameW+1)'(Frames));

  logic [FrameW-1:0] frame_sel;
  logic [PageW-1:0] victim_sel;
  logic [Pages-1:0] ref_n, mod_n, valid_n;
  logic [CfgDataW-1:0] tick_n;
  always_comb begin
    ref_n = ref_q;
    mod_n = mod_q;
    valid_n = valid_q;
    if (op_q) mod_n[page_q] = 1'b1;
    frame_sel = page_frame_q[page_q];
    victim_sel = '0;
    if (!valid_q[page_q]) begin
      if (has_free) begin
        frame_sel = free_idx;
      end else begin
        if (policy_i == PolNru) begin
          victim_sel = best_q;
          frame_sel = page_frame_q[best_q];
        end else begin
          frame_sel = (policy_i == PolFifo) ? hand_q : hand_scan_q;
          victim_sel = owner_q[frame_sel];
        end
        valid_n[victim_sel] = 1'b0;
        ref_n[victim_sel] = 1'b0;
        mod_n[victim_sel] = 1'b0;
      end
      valid_n[page_q] = 1'b1;
    end
    ref_n[page_q] = 1'b1;
    tick_n = tick_q + 1'b1;
    if (tick_n >= period_i) begin
      ref_n = '0;
      tick_n = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      ref_q <= '0;
      mod_q <= '0;
      used_q <= '0;
      hand_q <= '0;
      tick_q <= '0;
    end else if (cmd_i.commit) begin
      valid_q <= valid_n;
      ref_q <= ref_n;
      mod_q <= mod_n;
      tick_q <= tick_n;
      if (!valid_q[page_q]) begin
        used_q[frame_sel] <= 1'b1;
        if (!has_free) hand_q <= frame_sel + 1'b1;
      end
    end else if (cmd_i.clock_step && !stat_o.clock_found) begin
      ref_q[clk_owner] <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      op_q <= op_i;
      page_q <= addr_i[OffW +: PageW];
      off_q <= addr_i[OffW-1:0];
      scan_q <= '0;
      best_cls_q <= 3'd4;
      best_q <= '0;
      hand_scan_q <= hand_q;
      clock_cnt_q <= '0;
    end
    if (cmd_i.nru_step) begin
      if (scan_cls < best_cls_q && valid_q[scan_idx]) begin
        best_cls_q <= scan_cls;
        best_q <= scan_idx;
      end
      scan_q <= scan_q + 1'b1;
    end
    if (cmd_i.clock_step && !stat_o.clock_found) begin
      hand_scan_q <= hand_scan_q + 1'b1;
      clock_cnt_q <= clock_cnt_q + 1'b1;
    end
    if (cmd_i.commit) begin
      if (!valid_q[page_q]) begin
        page_frame_q[page_q] <= frame_sel;
        owner_q[frame_sel] <= page_q;
      end
      miss_o <= !valid_q[page_q];
      evicted_o <= !valid_q[page_q] && !has_free;
      victim_page_o <= victim_sel;
      frame_index_o <= frame_sel;
      paddr_o <= PhysW'({frame_sel, off_q});
    end
  end
endmodule

>>> rtl/demand_paging_replacement_unit.sv
// Sequence: a hit, a free-frame load or a FIFO eviction goes from lookup to commit to the
// result; an NRU eviction first scans every page, second chance first walks the clock hand.
// One transaction at a time: a new access is taken only after the result has been accepted.
// Reset (rst_ni low, asynchronous) empties the page table and sets second chance policy
// and a refresh period of four accesses.
module demand_paging_replacement_unit (
  input logic clk_i,
  input logic rst_ni,
  dpru_stream_if.sink in_if,
  dpru_stream_if.source out_if,
  input logic cfg_we_i,
  input logic [dpru_pkg::CfgIdxW-1:0] cfg_idx_i,
  input logic [dpru_pkg::CfgDataW-1:0] cfg_data_i
);
  import dpru_pkg::*;

  // Configuration registers: the user must write only while the unit is idle; unchecked.
  logic [1:0] policy_q;
  logic [CfgDataW-1:0] period_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q <= PolClock;
      period_q <= CfgDataW'(4);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgPolicy: policy_q <= cfg_data_i[1:0];
        CfgRefresh: period_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  cmd_t cmd;
  stat_t stat;

  // The controller sequences lookup, victim search and commit; the datapath
  // holds the tables and result register.
  dpru_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(in_if.valid),
    .in_ready_o(in_if.ready),
    .out_ready_i(out_if.ready),
    .policy_i(policy_q),
    .stat_i(stat),
    .cmd_o(cmd)
  );

  // Input payload: {op, logical_address}. Output: {fault, frame, phys, evicted, victim}.
  logic pf, ev;
  logic [FrameW-1:0] fr;
  logic [PhysW-1:0] pa;
  logic [PageW-1:0] vp;
  dpru_datapath u_dp (
    .clk_i, .rst_ni,
    .cmd_i(cmd),
    .stat_o(stat),
    .policy_i(policy_q),
    .period_i(period_q),
    .op_i(in_if.data[AddrW]),
    .addr_i(in_if.data[AddrW-1:0]),
    .miss_o(pf),
    .frame_index_o(fr),
    .paddr_o(pa),
    .evicted_o(ev),
    .victim_page_o(vp)
  );

  assign out_if.valid = cmd.out_valid;
  assign out_if.data = {pf, fr, pa, ev, vp};
endmodule

>>> rtl/dpru_checker.sv
// Port-level checker for the paging unit, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"
module dpru_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic [17:0] out_data_i
);
  `ASSERT_CLK(a_excl, clk_i, rst_ni, !(in_ready_i && out_valid_i), "ready while result pending")
  `ASSERT_CLK(a_hold, clk_i, rst_ni, out_valid_i && !out_ready_i |=> $stable(out_data_i), "result changed")
  `ASSERT_CLK(a_evf, clk_i, rst_ni, out_valid_i && out_data_i[4] |-> out_data_i[17], "evict no fault")
  `ASSERT_CLK(a_vz, clk_i, rst_ni, out_valid_i && !out_data_i[4] |-> out_data_i[3:0] == 4'd0, "victim")
endmodule

bind demand_paging_replacement_unit dpru_checker u_chk (
  .clk_i(clk_i), .rst_ni(rst_ni),
  .in_valid_i(in_if.valid), .in_ready_i(in_if.ready),
  .out_valid_i(out_if.valid), .out_ready_i(out_if.ready),
  .out_data_i(out_if.data)
);

>>> tb/demand_paging_replacement_unit_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for demand_paging_replacement_unit.
// Depends on dpru_pkg, dpru_stream_if and the unit itself; it predicts each
// translation in a behavioral page table and compares every result field.
module demand_paging_replacement_unit_tb;
  import dpru_pkg::*;

  localparam int unsigned InW = 1 + AddrW;
  localparam int unsigned OutW = 1 + FrameW + PhysW + 1 + PageW;
  localparam int unsigned DrainCycles = 30;
  localparam int unsigned StallLimit = 5000;

  // One memory access as the unit sees it: the access kind sits above the address.
  typedef struct packed {
    logic op;
    logic [AddrW-1:0] addr;
  } access_t;

  // One translation result, fields in the order of the output payload.
  typedef struct packed {
    logic miss;
    logic [FrameW-1:0] frame_index;
    logic [PhysW-1:0] phys_addr;
    logic evicted;
    logic [PageW-1:0] victim_page;
  } xlate_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  dpru_stream_if #(.W(InW)) in_if ();
  dpru_stream_if #(.W(OutW)) out_if ();

  demand_paging_replacement_unit dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_if(in_if),
    .out_if(out_if),
    .cfg_we_i(cfg_we_i),
    .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  // Shadow page table. It is updated at the moment a transaction is accepted,
  // so the queue of expected translations always matches the unit's order.
  logic [FrameW-1:0] pt_frame [Pages];
  logic pt_valid [Pages];
  logic pt_ref [Pages];
  logic pt_mod [Pages];
  logic fr_used [Frames];
  logic [PageW-1:0] fr_owner [Frames];
  logic [FrameW-1:0] hand;
  logic [7:0] ticks;
  policy_e policy;
  logic [7:0] refresh_period;

  xlate_t expected_xlates [$];
  int errors = 0;
  int hits = 0;
  int faults = 0;
  int evictions = 0;
  int accepted = 0;
  int idle_cycles = 0;
  bit calm = 0;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic void clear_page_table();
    for (int p = 0; p < Pages; p++) begin
      pt_frame[p] = '0;
      pt_valid[p] = 1'b0;
      pt_ref[p] = 1'b0;
      pt_mod[p] = 1'b0;
    end
    for (int f = 0; f < Frames; f++) begin
      fr_used[f] = 1'b0;
      fr_owner[f] = '0;
    end
    hand = '0;
    ticks = '0;
    policy = PolClock;
    refresh_period = 8'd4;
  endfunction

  // Computes the translation of one access and advances the shadow state.
  function automatic xlate_t translate(access_t a);
    xlate_t r;
    logic [PageW-1:0] page;
    logic [PageW-1:0] victim;
    logic [FrameW-1:0] frame;
    logic found;
    logic [1:0] cls;
    logic [2:0] best_cls;
    page = a.addr[OffW +: PageW];
    victim = '0;
    r = '0;
    if (a.op) pt_mod[page] = 1'b1;
    if (pt_valid[page]) begin
      frame = pt_frame[page];
      pt_ref[page] = 1'b1;
    end else begin
      r.miss = 1'b1;
      found = 1'b0;
      frame = '0;
      for (int f = 0; f < Frames; f++) begin
        if (!found && !fr_used[f]) begin
          found = 1'b1;
          frame = f[FrameW-1:0];
        end
      end
      if (found) begin
        fr_used[frame] = 1'b1;
      end else begin
        if (policy == PolNru) begin
          // Lowest class R*2+M wins; ties go to the lowest page number.
          best_cls = 3'd4;
          for (int p = 0; p < Pages; p++) begin
            cls = {pt_ref[p], pt_mod[p]};
            if (pt_valid[p] && {1'b0, cls} < best_cls) begin
              best_cls = {1'b0, cls};
              victim = p[PageW-1:0];
            end
          end
          frame = pt_frame[victim];
        end else begin
          frame = hand;
          if (policy != PolFifo) begin
            // Second chance: walk the clock, clearing R until an unreferenced
            // owner turns up; after a full lap plus one step it stops anyway.
            found = 1'b0;
            for (int n = 0; n <= Frames; n++) begin
              if (!found) begin
                if (!pt_ref[fr_owner[frame]]) found = 1'b1;
                else begin
                  pt_ref[fr_owner[frame]] = 1'b0;
                  frame = frame + 1'b1;
                end
              end
            end
          end
          victim = fr_owner[frame];
        end
        r.evicted = 1'b1;
        pt_valid[victim] = 1'b0;
        pt_ref[victim] = 1'b0;
        pt_mod[victim] = 1'b0;
        hand = frame + 1'b1;
      end
      fr_owner[frame] = page;
      pt_frame[page] = frame;
      pt_valid[page] = 1'b1;
      pt_ref[page] = 1'b1;
    end
    ticks = ticks + 8'd1;
    if (ticks >= refresh_period) begin
      for (int p = 0; p < Pages; p++) pt_ref[p] = 1'b0;
      ticks = '0;
    end
    r.frame_index = frame;
    r.phys_addr = {frame, a.addr[OffW-1:0]};
    r.victim_page = victim;
    return r;
  endfunction

  // Sends one access; valid stays high afterwards so back-to-back transactions
  // need no extra assignment. A random gap may come first.
  task automatic send_access(logic op, logic [AddrW-1:0] addr);
    access_t a;
    xlate_t r;
    a.op = op;
    a.addr = addr;
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data <= a;
    do @(posedge clk_i); while (!in_if.ready);
    r = translate(a);
    expected_xlates.push_back(r);
    accepted++;
    if (r.miss) faults++;
    else hits++;
    if (r.evicted) evictions++;
  endtask

  // Lowers valid and waits until every expected translation has come back.
  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (expected_xlates.size() != 0) @(posedge clk_i);
  endtask

  // Register writes happen only with the unit idle; the extra cycles cover
  // any work the unit might still be winding down.
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    drain();
    repeat (DrainCycles) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CfgPolicy) policy = policy_e'(val[1:0]);
    else refresh_period = val;
  endtask

  // Random access: mostly a small working set so hits, loads and evictions
  // all happen often; now and then any address at all.
  task automatic send_random();
    logic [PageW-1:0] page;
    if ($urandom_range(0, 7) == 0) begin
      send_access(1'($urandom_range(0, 1)), AddrW'($urandom_range(0, 4095)));
    end else begin
      page = PageW'($urandom_range(0, 5) + $urandom_range(0, 1) * 4);
      send_access(1'($urandom_range(0, 1)), {page, 8'($urandom_range(0, 255))});
    end
  endtask

  // Directed: reset settings, filling the free frames, hits with and without
  // writes, address extremes and page wraparound, then evictions.
  task automatic test_directed();
    send_access(1'b0, 12'h000);
    send_access(1'b1, 12'hFFF);
    send_access(1'b0, 12'h0FF);
    send_access(1'b1, 12'h100);
    send_access(1'b0, 12'h2AB);
    send_access(1'b1, 12'hF00);
    send_access(1'b0, 12'h354);
    send_access(1'b0, 12'h7FF);
    send_access(1'b1, 12'h800);
    send_access(1'b0, 12'h000);
    send_access(1'b1, 12'h355);
    send_access(1'b0, 12'h5CA);
    send_access(1'b0, 12'hA35);
    send_access(1'b1, 12'h6E1);
  endtask

  // One policy and refresh setting, an access to each of six pages, then random traffic.
  task automatic test_policy(policy_e pol, logic [7:0] period, int count);
    write_reg(CfgPolicy, CfgDataW'(pol));
    write_reg(CfgRefresh, period);
    for (int p = 0; p < 6; p++) send_access(p[0], {p[PageW-1:0], 8'hA5});
    for (int i = 0; i < count; i++) send_random();
  endtask

  // The sender holds off until the unit has returned every result.
  task automatic test_pause();
    for (int i = 0; i < 10; i++) send_random();
    drain();
    for (int i = 0; i < 10; i++) send_random();
  endtask

  // Result side: stall in random bursts until the quiet phase.
  int stall_left = 0;
  always @(posedge clk_i) begin
    if (calm) begin
      out_if.ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_if.ready <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 12);
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  // Compare each returned transaction with the oldest prediction.
  always @(posedge clk_i) begin
    xlate_t got;
    xlate_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got = out_if.data;
      if (expected_xlates.size() == 0) begin
        $display("%0t: unexpected result %p", $time, got);
        errors++;
      end else begin
        want = expected_xlates.pop_front();
        if (got.miss !== want.miss) begin
          $display("%0t: fault flag expected %0d got %0d", $time, want.miss,
                   got.miss);
          errors++;
        end
        if (got.frame_index !== want.frame_index) begin
          $display("%0t: frame_index expected %0d got %0d", $time, want.frame_index,
                   got.frame_index);
          errors++;
        end
        if (got.phys_addr !== want.phys_addr) begin
          $display("%0t: translated address expected %h got %h", $time, want.phys_addr,
                   got.phys_addr);
          errors++;
        end
        if (got.evicted !== want.evicted) begin
          $display("%0t: evicted expected %0d got %0d", $time, want.evicted, got.evicted);
          errors++;
        end
        if (got.victim_page !== want.victim_page) begin
          $display("%0t: victim_page expected %0d got %0d", $time, want.victim_page,
                   got.victim_page);
          errors++;
        end
      end
    end
  end

  // Watchdog: a long stretch with no transaction on either side means a hang.
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || !rst_ni) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    in_if.valid = 1'b0;
    in_if.data = '0;
    out_if.ready = 1'b0;
    clear_page_table();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_policy(PolNru, 8'd1, 190);
    test_policy(PolFifo, 8'd255, 190);
    test_pause();
    test_policy(PolClock, 8'd4, 190);
    test_policy(PolClockAlt, 8'd7, 190);
    test_policy(PolNru, 8'd13, 190);
    test_policy(PolClock, 8'd255, 190);
    test_policy(PolFifo, 8'd1, 190);
    calm = 1'b1;
    test_policy(PolNru, 8'd255, 190);

    drain();
    repeat (DrainCycles) @(posedge clk_i);
    $display("Ran %0d accesses over all four policy codes: %0d hits, %0d faults,",
             accepted, hits, faults);
    $display("%0d evictions, refresh periods from 1 to 255, with stalls on both sides.",
             evictions);
    if (errors == 0 && expected_xlates.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule

>>> sim.f
+incdir+rtl
rtl/dpru_pkg.sv
rtl/dpru_stream_if.sv
rtl/dpru_ctrl.sv
rtl/dpru_datapath.sv
rtl/demand_paging_replacement_unit.sv
rtl/dpru_checker.sv
tb/demand_paging_replacement_unit_tb.sv
